[hw/rtl/sitda_pkg.sv]
// Shared types and character constants for the signed integer to decimal text block.
// Used by the controller, the datapath and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

    // ASCII codes of the characters that the block emits.
    localparam logic [6:0] CHAR_MINUS = 7'd45;
    localparam logic [6:0] CHAR_ZERO  = 7'd48;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // take a new input item
        logic conv_step;   // one double-dabble shift
        logic skip_step;   // drop one leading zero digit
        logic emit_sign;   // put the minus sign in the output register
        logic emit_digit;  // put the top digit in the output register
    } sitda_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic last_bit;    // the conversion is on its final bit
        logic top_zero;    // the most significant remaining digit is zero
        logic one_left;    // only one digit remains
        logic negative;    // the item was negative
        logic slot_free;   // the output register can take a character
    } sitda_sts_t;

endpackage

`default_nettype wire

[hw/rtl/sitda_ctrl.sv]
// Sequencer for the signed integer to decimal text block.
// Depends on sitda_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module sitda_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  src_valid,
    output logic                       src_stall,
    input  wire sitda_pkg::sitda_sts_t sts,
    output sitda_pkg::sitda_cmd_t      cmd
);
    import sitda_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CONV   = 3'd1;
    localparam logic [2:0] S_SKIP   = 3'd2;
    localparam logic [2:0] S_SIGN   = 3'd3;
    localparam logic [2:0] S_DIGITS = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // A new item is taken only while the sequencer is idle.
    assign src_stall = (state_reg != S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (src_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (sts.last_bit)
                begin
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                if (sts.top_zero && !sts.one_left)
                begin
                    cmd.skip_step = 1'b1;
                end
                else if (sts.negative)
                begin
                    state_next = S_SIGN;
                end
                else
                begin
                    state_next = S_DIGITS;
                end
            end
            S_SIGN:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = S_DIGITS;
                end
            end
            S_DIGITS:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (sts.one_left)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sitda_datapath.sv]
// Datapath: magnitude register, bit-serial double-dabble BCD register and output register.
// Depends on sitda_pkg for the command and status structs and the character codes.
`timescale 1ns / 1ps
`default_nettype none

module sitda_datapath #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic signed [VALUE_BITS-1:0] value,
    input  wire sitda_pkg::sitda_cmd_t        cmd,
    output sitda_pkg::sitda_sts_t             sts,
    output logic [6:0]                        character,
    output logic                              last,
    output logic                              dst_valid,
    input  wire logic                         dst_stall
);
    import sitda_pkg::*;

    // Decimal digits needed for any VALUE_BITS-bit unsigned magnitude.
    localparam int NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int NB    = NDIG * 4;
    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam int DIG_W = $clog2(NDIG + 1);

    logic [VALUE_BITS-1:0] mag_reg;
    logic [NB-1:0]         bcd_reg;
    logic [NB-1:0]         bcd_adj;
    logic [CNT_W-1:0]      bit_cnt_reg;
    logic [DIG_W-1:0]      dig_left_reg;
    logic                  neg_reg;
    logic [6:0]            character_reg;
    logic                  last_reg;
    logic                  valid_reg;
    logic [3:0]            top_digit;

    // Add three to every digit of five or more before the shift.
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    assign top_digit = bcd_reg[NB-1 -: 4];

    // Status back to the controller.
    always_comb
    begin
        sts.last_bit  = (bit_cnt_reg == CNT_W'(VALUE_BITS - 1));
        sts.top_zero  = (top_digit == 4'd0);
        sts.one_left  = (dig_left_reg == DIG_W'(1));
        sts.negative  = neg_reg;
        sts.slot_free = !valid_reg || !dst_stall;
    end

    // Magnitude, BCD digits and counters; payload, so no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg      <= value[VALUE_BITS-1];
            mag_reg      <= value[VALUE_BITS-1] ? ((~value) + 1'b1) : value;
            bcd_reg      <= '0;
            bit_cnt_reg  <= '0;
            dig_left_reg <= DIG_W'(NDIG);
        end
        else if (cmd.conv_step)
        begin
            bcd_reg     <= {bcd_adj[NB-2:0], mag_reg[VALUE_BITS-1]};
            mag_reg     <= {mag_reg[VALUE_BITS-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg + 1'b1;
        end
        else if (cmd.skip_step || cmd.emit_digit)
        begin
            bcd_reg      <= {bcd_reg[NB-5:0], 4'd0};
            dig_left_reg <= dig_left_reg - 1'b1;
        end
    end

    // Output character register.
    always_ff @(posedge clk)
    begin
        if (cmd.emit_sign)
        begin
            character_reg <= CHAR_MINUS;
            last_reg      <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            character_reg <= CHAR_ZERO + {3'd0, top_digit};
            last_reg      <= sts.one_left;
        end
    end

    // Output valid: set on an emit, cleared once the item is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.emit_sign || cmd.emit_digit)
        begin
            valid_reg <= 1'b1;
        end
        else if (!dst_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign character = character_reg;
    assign last      = last_reg;
    assign dst_valid = valid_reg;

endmodule

`default_nettype wire

[hw/rtl/signed_int_to_decimal_ascii.sv]
// Signed integer to decimal ASCII text, one character per output item, last marked.
// The first character comes after the conversion of all VALUE_BITS bits and the
// skip of leading zero digits; no new item is taken until the current item's last digit is emitted.
// NDIG is the digit count of the BCD register (10 at 32 bits).
// The conversion is a bit-serial double-dabble, and the zero skip drops one digit a cycle.
// Reset clears the sequencer and the output valid; no item is in flight after it.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         src_valid,
    output logic                              src_stall,
    input  wire logic signed [VALUE_BITS-1:0] value,
    output logic                              dst_valid,
    input  wire logic                         dst_stall,
    output logic [6:0]                        character,
    output logic                              last
);
    import sitda_pkg::*;

    sitda_cmd_t cmd;
    sitda_sts_t sts;

    sitda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    sitda_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .sts       (sts),
        .character (character),
        .last      (last),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall)
    );

    // The block is busy right after taking an item.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid && !src_stall) |=> src_stall)
        else $error("block not busy after accepting an item");

    // At most one datapath command at a time.
    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");

    // Only a minus sign or a decimal digit is ever presented.
    a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> (character == CHAR_MINUS ||
                       (character >= CHAR_ZERO && character <= CHAR_ZERO + 7'd9)))
        else $error("illegal output character");

    // The minus sign is never the final character.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && character == CHAR_MINUS) |-> !last)
        else $error("minus sign marked last");

endmodule

`default_nettype wire

[sim/tb_signed_int_to_decimal_ascii.sv]
// Testbench for signed_int_to_decimal_ascii: random and directed integers are converted,
// and each emitted character is checked against a decimal text predictor kept here.
// Depends on sitda_pkg and the signed_int_to_decimal_ascii RTL.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;

    import sitda_pkg::*;

    localparam int VALUE_BITS  = 32;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 60;

    // One character of the expected decimal text.
    typedef struct {
        logic [6:0] code;
        logic       is_last;
    } text_char_t;

    logic                         clk;
    logic                         rst_n        = 1'b0;
    logic                         src_valid    = 1'b0;
    logic                         src_stall;
    logic signed [VALUE_BITS-1:0] value        = '0;
    logic                         dst_valid;
    logic                         dst_stall    = 1'b0;
    logic [6:0]                   character;
    logic                         last;

    logic [VALUE_BITS-1:0] pending_values[$];
    text_char_t            expected_chars[$];

    int  send_idle_pct   = 0;
    int  recv_stall_pct  = 0;
    bit  hold_trigger    = 1'b0;
    bit  hold_seen       = 1'b0;
    int  hold_left       = 0;
    int  idle_cycles     = 0;
    int  mismatches      = 0;
    int  numbers_taken   = 0;
    int  negatives_taken = 0;
    int  chars_checked   = 0;

    signed_int_to_decimal_ascii #(
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .value     (value),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .character (character),
        .last      (last)
    );

    // Clock with a 2 ns period.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Works out the characters of one number: sign first, then digits, top digit first.
    function automatic void predict_decimal_text(logic [VALUE_BITS-1:0] raw);
        logic [VALUE_BITS-1:0] magnitude;
        logic [3:0]            digits[$];
        text_char_t            c;
        magnitude = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
        do
        begin
            digits.push_front(4'(magnitude % 10));
            magnitude = magnitude / 10;
        end
        while (magnitude != 0);
        if (raw[VALUE_BITS-1])
        begin
            c.code    = CHAR_MINUS;
            c.is_last = 1'b0;
            expected_chars.push_back(c);
            negatives_taken++;
        end
        for (int k = 0; k < digits.size(); k++)
        begin
            c.code    = CHAR_ZERO + 7'(digits[k]);
            c.is_last = (k == digits.size() - 1);
            expected_chars.push_back(c);
        end
        numbers_taken++;
    endfunction

    // Random number: either fully random bits or a random digit count with a random sign.
    function automatic logic [VALUE_BITS-1:0] random_number();
        longint lo;
        longint hi;
        longint mag;
        int     ndig;
        if ($urandom_range(2) == 0)
            return $urandom;
        ndig = $urandom_range(10, 1);
        lo   = (ndig == 1) ? 0 : 10 ** (ndig - 1);
        hi   = (ndig == 10) ? 64'd2147483647 : 10 ** ndig - 1;
        mag  = lo + (longint'($urandom) % (hi - lo + 1));
        return ($urandom_range(1) == 1) ? -mag[VALUE_BITS-1:0] : mag[VALUE_BITS-1:0];
    endfunction

    // Sender: offers the next pending item once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            value     <= '0;
        end
        else
        begin
            if (src_valid && !src_stall)
                predict_decimal_text(value);
            if (!src_valid || !src_stall)
            begin
                if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    value     <= pending_values.pop_front();
                    src_valid <= 1'b1;
                end
                else
                begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: random, or held high for a long stretch when asked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_stall <= 1'b0;
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_trigger != hold_seen)
        begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
            dst_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            dst_stall <= 1'b1;
        end
        else
        begin
            dst_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Checks each character taken against the oldest expected one.
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("character: expected none, got %0d (last %0b)", character, last);
                mismatches++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (character !== want.code)
                begin
                    $error("character: expected %0d, got %0d", want.code, character);
                    mismatches++;
                end
                if (last !== want.is_last)
                begin
                    $error("last: expected %0b, got %0b", want.is_last, last);
                    mismatches++;
                end
            end
            chars_checked++;
        end
    end

    // Watchdog: ends the run when nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Waits until every item is taken and every character has come out.
    task automatic wait_drained();
        while (pending_values.size() != 0 || src_valid || expected_chars.size() != 0)
            @(posedge clk);
    endtask

    // One phase of random items in two halves, with the sender pausing in between.
    task automatic run_phase(int count, int idle_pct, int stall_pct, bit hold_off);
        send_idle_pct  <= idle_pct;
        recv_stall_pct <= stall_pct;
        @(posedge clk);
        if (hold_off)
            hold_trigger <= ~hold_trigger;
        for (int i = 0; i < count / 2; i++)
            pending_values.push_back(random_number());
        wait_drained();
        for (int i = count / 2; i < count; i++)
            pending_values.push_back(random_number());
        wait_drained();
    endtask

    // Stimulus: directed corner values, then random phases with varied idling.
    initial
    begin
        logic [VALUE_BITS-1:0] corner_values[$];
        corner_values = '{32'd0, 32'd1, -32'sd1, 32'd7, 32'd9, -32'sd9, 32'd10, -32'sd10,
                          32'd99, 32'd100, -32'sd100, 32'd1000, 32'd12345, 32'd999999999,
                          -32'sd999999999, 32'd1000000000, 32'd1234567890, -32'sd987654321,
                          32'd1999999999, 32'd2147483647, -32'sd2147483647,
                          32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_values[i])
            pending_values.push_back(corner_values[i]);
        wait_drained();

        run_phase(30, 0, 0, 1'b0);
        run_phase(30, 51, 0, 1'b0);
        run_phase(30, 0, 51, 1'b0);
        run_phase(30, 10, 10, 1'b0);
        run_phase(30, 0, 0, 1'b1);

        repeat (DRAIN_WAIT) @(posedge clk);
        if (expected_chars.size() != 0)
        begin
            $error("character: %0d expected characters never came out",
                   expected_chars.size());
            mismatches++;
        end

        $display("Converted %0d numbers (%0d negative), %0d characters checked.",
                 numbers_taken, negatives_taken, chars_checked);
        $display("Phases: no idling, sender idle, receiver stall, both, long receiver hold.");
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
